// ===== hw/rtl/periodic_timer_slot_table_assert.svh =====
// Assertion macros shared by the checker of the periodic timer slot table.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PERIODIC_TIMER_SLOT_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_SLOT_TABLE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define PTST_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define PTST_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== hw/rtl/ptst_pkg.sv =====
// Types and codes for the periodic timer slot table.
// No dependencies; imported by every module of the block.
package ptst_pkg;

  localparam logic [1:0] OP_ALLOCATE = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_SCAN     = 2'd3;

  localparam logic [1:0] KIND_ALLOCATED = 2'd0;
  localparam logic [1:0] KIND_FULL      = 2'd1;
  localparam logic [1:0] KIND_DUE       = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // One slot entry of the period/count memory.
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] count;
  } ptst_ent_t;

  // One result beat handed from the sequencer to the output register.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [3:0] slot_id;
    logic       last;
  } ptst_res_t;

endpackage

// ===== hw/rtl/ptst_ram.sv =====
// Period/count memory of the slot table: one write and one read port,
// registered read data. Uses ptst_pkg for the entry type.
module ptst_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ptst_pkg::ptst_ent_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output ptst_pkg::ptst_ent_t rd_data
);
  import ptst_pkg::*;

  ptst_ent_t mem [DEPTH];
  ptst_ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/ptst_ctrl.sv =====
// Sequencer of the slot table: active bits, free-slot walk, tick and scan
// sweeps over the period/count memory. Uses ptst_pkg; drives ptst_ram.
module ptst_ctrl #(
  parameter int SLOTS = 8,
  parameter int IW    = 3,
  parameter int CW    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [15:0]         in_period,
  input  logic [3:0]          in_slot,
  input  logic                out_free,
  output ptst_pkg::ptst_res_t push,
  output logic                rd_en,
  output logic [IW-1:0]       rd_addr,
  input  ptst_pkg::ptst_ent_t rd_data,
  output logic                wr_en,
  output logic [IW-1:0]       wr_addr,
  output ptst_pkg::ptst_ent_t wr_data
);
  import ptst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    ev_idx_r, ev_idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [15:0]      period_r, period_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [3:0]       pend_id_r, pend_id_nxt;

  logic       sweeping, more, ev_due, stall;
  logic       free_here, last_here, alloc_go;
  logic [3:0] ev_id, cur_id;

  assign in_ready  = (state_r == S_IDLE);
  assign sweeping  = (state_r == S_TICK) || (state_r == S_SCAN);
  assign more      = (idx_r != CW'(SLOTS));
  assign ev_due    = active_r[ev_idx_r] && (rd_data.count >= rd_data.period);
  assign ev_id     = 4'(ev_idx_r) + 4'd1;
  assign cur_id    = 4'(idx_r) + 4'd1;
  // Hold the sweep while a due slot needs the pending beat moved on.
  assign stall     = (state_r == S_SCAN) && rd_pend_r && ev_due && pend_v_r && !out_free;
  assign free_here = !active_r[idx_r[IW-1:0]];
  assign last_here = (idx_r == CW'(SLOTS - 1));
  assign alloc_go  = (state_r == S_ALLOC) && (free_here || last_here) && out_free;

  assign rd_en   = sweeping && !stall && more;
  assign rd_addr = idx_r[IW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ev_idx_r;
    wr_data = '{period: rd_data.period, count: 16'd0};
    push    = '{valid: 1'b0, kind: KIND_DUE, slot_id: pend_id_r, last: 1'b0};
    case (state_r)
      S_ALLOC: begin
        wr_en   = alloc_go && free_here;
        wr_addr = idx_r[IW-1:0];
        wr_data = '{period: period_r, count: 16'd0};
        push    = '{valid: alloc_go,
                    kind: free_here ? KIND_ALLOCATED : KIND_FULL,
                    slot_id: free_here ? cur_id : 4'd0,
                    last: 1'b1};
      end
      S_TICK: begin
        wr_en   = rd_pend_r;
        wr_data = '{period: rd_data.period,
                    count: (rd_data.count == COUNT_MAX) ? COUNT_MAX
                                                        : rd_data.count + 16'd1};
      end
      S_SCAN: begin
        wr_en      = rd_pend_r && ev_due && !stall;
        push.valid = rd_pend_r && ev_due && pend_v_r && !stall;
      end
      S_FLUSH: begin
        push.valid = pend_v_r && out_free;
        push.last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    ev_idx_nxt  = ev_idx_r;
    rd_pend_nxt = rd_pend_r;
    active_nxt  = active_r;
    period_nxt  = period_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt     = '0;
          rd_pend_nxt = 1'b0;
          pend_v_nxt  = 1'b0;
          case (in_operation)
            OP_ALLOCATE: begin
              period_nxt = in_period;
              state_nxt  = S_ALLOC;
            end
            OP_RELEASE: begin
              for (int i = 0; i < SLOTS; i++) begin
                if (int'(in_slot) == i + 1) begin
                  active_nxt[i] = 1'b0;
                end
              end
            end
            OP_TICK: state_nxt = S_TICK;
            OP_SCAN: state_nxt = S_SCAN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (alloc_go) begin
          if (free_here) begin
            active_nxt[idx_r[IW-1:0]] = 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (!(free_here || last_here)) begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_TICK, S_SCAN: begin
        if (!stall) begin
          if ((state_r == S_SCAN) && rd_pend_r && ev_due) begin
            pend_v_nxt  = 1'b1;
            pend_id_nxt = ev_id;
          end
          rd_pend_nxt = more;
          if (more) begin
            ev_idx_nxt = idx_r[IW-1:0];
            idx_nxt    = idx_r + CW'(1);
          end else begin
            state_nxt = (state_r == S_SCAN) ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_r || out_free) begin
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
      active_r  <= '0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      active_r  <= active_nxt;
      pend_v_r  <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    ev_idx_r  <= ev_idx_nxt;
    period_r  <= period_nxt;
    pend_id_r <= pend_id_nxt;
  end

endmodule

// ===== hw/rtl/periodic_timer_slot_table.sv =====
// Top level of the periodic timer slot table: sequencer, period/count memory
// and the result output register. Uses ptst_pkg, ptst_ctrl and ptst_ram.

// Keeps SLOTS periodic timers, numbered 1 to SLOTS. One item is worked on at a
// time; in_ready is high whenever the sequencer is idle, also while a result
// beat still waits on the output. A release clears the active bit of its slot
// and leaves the sequencer idle. An allocate walks the active bits one slot a
// cycle from slot 1 and finishes on the first free slot, or reports the table
// full on the last one, once the output register is free. A tick or a scan
// sweeps the period/count memory through its single read and single write port,
// one slot a cycle while a scan is not held by the output, with the write-back
// of each slot following its registered read. A scan reports each due slot in
// ascending order, with last set on the highest one. Counts saturate at 65535;
// no clearing pass runs after reset.
module periodic_timer_slot_table #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_period,
  input  logic [3:0]  in_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_slot_id,
  output logic        out_last
);
  import ptst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  ptst_res_t     push;
  ptst_ent_t     rd_data, wr_data;
  logic          rd_en, wr_en, out_free;
  logic [IW-1:0] rd_addr, wr_addr;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r;
  logic [3:0] out_slot_id_r;
  logic       out_last_r;

  assign out_free = !out_valid_r || out_ready;

  ptst_ctrl #(
    .SLOTS (SLOTS),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_period    (in_period),
    .in_slot      (in_slot),
    .out_free     (out_free),
    .push         (push),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  ptst_ram #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the beat only when the register is free; the sequencer never pushes otherwise.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_kind_r    <= push.kind;
      out_slot_id_r <= push.slot_id;
      out_last_r    <= push.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_slot_id = out_slot_id_r;
  assign out_last    = out_last_r;

endmodule

// ===== hw/rtl/ptst_checker.sv =====
// Port-level checker for the periodic timer slot table, bound to the top level.
// Uses ptst_pkg and the macros of periodic_timer_slot_table_assert.svh.
`include "periodic_timer_slot_table_assert.svh"

module ptst_checker #(
  parameter int SLOTS = 8
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [3:0] out_slot_id,
  input logic       out_last
);
  import ptst_pkg::*;

  `PTST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_slot_id) && $stable(out_last), "result beat changed while stalled")
  `PTST_ASSERT_SAME(a_full_beat, out_valid && (out_kind == KIND_FULL), (out_slot_id == 4'd0) && out_last, "table-full beat malformed")
  `PTST_ASSERT_SAME(a_alloc_beat, out_valid && (out_kind == KIND_ALLOCATED), out_last && (out_slot_id != 4'd0) && (int'(out_slot_id) <= SLOTS), "allocate beat malformed")
  `PTST_ASSERT_SAME(a_due_beat, out_valid && (out_kind == KIND_DUE), (out_slot_id != 4'd0) && (int'(out_slot_id) <= SLOTS), "due beat names no slot")
  `PTST_ASSERT_SAME(a_kind_code, out_valid, (out_kind == KIND_ALLOCATED) || (out_kind == KIND_FULL) || (out_kind == KIND_DUE), "unknown result kind")

endmodule

bind periodic_timer_slot_table ptst_checker #(
  .SLOTS (SLOTS)
) u_ptst_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_kind    (out_kind),
  .out_slot_id (out_slot_id),
  .out_last    (out_last)
);
